>>> design/tcs_pkg.sv
// ----------------------------------------------------------------------------
// Text console package
// Opcodes, register indexes, cell constants and the command and status
// words that pass between the console controller and its datapath.
// ----------------------------------------------------------------------------
package tcs_pkg;

   // Operation codes of a request word
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_MOVE  = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_LINE_WIDTH = 1'd0,
      CSR_LINE_COUNT = 1'd1
   } csr_type;

   localparam logic [15:0] BLANK_CELL       = 16'h0720;
   localparam logic [7:0]  TEXT_ATTR        = 8'h07;
   localparam logic [7:0]  NEWLINE          = 8'h0A;
   localparam logic [7:0]  PRINT_LO         = 8'h20;
   localparam logic [7:0]  PRINT_HI         = 8'h7E;
   localparam logic [6:0]  LINE_WIDTH_RESET = 7'd80;
   localparam logic [4:0]  LINE_COUNT_RESET = 5'd25;

   // Controller to datapath
   typedef struct packed {
      logic load;         // capture request word
      logic exec;         // decode and run the operation
      logic copy;         // one step of the scroll copy
      logic blank_start;  // point at the bottom row
      logic blank;        // blank one bottom-row cell
      logic clear;        // blank one cell of the full store
      logic finish;       // load the response registers
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   scroll;      // valid during exec
      logic   copy_done;
      logic   fill_last;
      logic   clear_last;
   } status_type;

endpackage

>>> design/text_console_cursor_scroll.sv
// A write without scroll, a read or a move passes from acceptance through the
// exec and done states to its response word; the done state waits while an
// earlier response is not yet taken. The next word is taken back in idle.
// A scroll adds a copy pass that moves each row up by one and a blanking pass
// over the bottom row. A clear sweeps the whole store, one cell a cycle.
// After reset the same clearing pass runs with req_ready low; configuration
// writes are taken throughout.
// ----------------------------------------------------------------------------
// Text console top level
// Character-cell console with cursor, line wrap and scrolling.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
   parameter int MAX_COLS = 80,
   parameter int MAX_ROWS = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   input  logic [4:0]  req_target_row,
   input  logic [6:0]  req_target_col,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   output logic [10:0] rsp_cursor_position,
   output logic [15:0] rsp_cell_data,
   output logic        rsp_scrolled
);

   tcs_pkg::cmd_type    cmd;
   tcs_pkg::status_type status;

   tcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcs_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_op              (req_op),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .req_target_row      (req_target_row),
      .req_target_col      (req_target_col),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_data       (rsp_cell_data),
      .rsp_scrolled        (rsp_scrolled)
   );

   // Reported cursor always lies inside the largest window
   a_cursor_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_row) < MAX_ROWS) && (32'(rsp_cursor_col) < MAX_COLS))
      else $error("cursor outside window");

   // A scroll leaves the cursor at column 0 and returns no cell data
   a_scroll_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cursor_col == 7'd0) && (rsp_cell_data == 16'd0))
      else $error("scroll response malformed");

   // No word is taken in the cycle after reset: the store is still clearing
   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

>>> design/tcs_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences each request word: decode, scroll copy and bottom-row blanking,
// full-store clear, and the response handshake.
// ----------------------------------------------------------------------------
module tcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tcs_pkg::status_type  status,
   output tcs_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_COPY,
      S_BLANK,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Commands decoded from the state
   always_comb begin
      cmd             = '0;
      cmd.load        = (state_ff == S_IDLE) && req_valid;
      cmd.exec        = (state_ff == S_EXEC);
      cmd.copy        = (state_ff == S_COPY) && !status.copy_done;
      cmd.blank_start = (state_ff == S_COPY) && status.copy_done;
      cmd.blank       = (state_ff == S_BLANK);
      cmd.clear       = (state_ff == S_INIT) || (state_ff == S_CLEAR);
      cmd.finish      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // State and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               if (status.clear_last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (status.op == tcs_pkg::OP_CLEAR) begin
                  state_ff <= S_CLEAR;
               end else if (status.scroll) begin
                  state_ff <= S_COPY;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_COPY: begin
               if (status.copy_done) state_ff <= S_BLANK;
            end
            S_BLANK: begin
               if (status.fill_last) state_ff <= S_DONE;
            end
            S_CLEAR: begin
               if (status.clear_last) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (cmd.finish) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_INIT;
            end
         endcase
      end
   end

endmodule

>>> design/tcs_dp.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Cell store, cursor, line registers, sweep pointer and response registers.
// ----------------------------------------------------------------------------
module tcs_dp #(
   parameter int MAX_COLS = 80,
   parameter int MAX_ROWS = 25
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcs_pkg::cmd_type     cmd,
   output tcs_pkg::status_type  status,
   input  logic                 csr_write_en,
   input  logic [0:0]           csr_index,
   input  logic [6:0]           csr_wdata,
   input  logic [1:0]           req_op,
   input  logic [7:0]           req_char_code,
   input  logic [10:0]          req_cell_index,
   input  logic [4:0]           req_target_row,
   input  logic [6:0]           req_target_col,
   output logic [4:0]           rsp_cursor_row,
   output logic [6:0]           rsp_cursor_col,
   output logic [10:0]          rsp_cursor_position,
   output logic [15:0]          rsp_cell_data,
   output logic                 rsp_scrolled
);

   localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
   localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int PW         = $clog2(CELL_COUNT + 1);

   // Cell store
   logic [15:0] mem [CELL_COUNT];
   logic [15:0] rd_q;

   // Configuration and cursor
   logic [6:0]  line_width_ff;
   logic [4:0]  line_count_ff;
   logic [4:0]  cur_row_ff;
   logic [6:0]  cur_col_ff;

   // Captured request word
   tcs_pkg::op_type op_ff;
   logic [7:0]  char_ff;
   logic [10:0] idx_ff;
   logic [4:0]  trow_ff;
   logic [6:0]  tcol_ff;

   // Sweep control
   logic [PW-1:0] ptr_ff;
   logic [PW-1:0] base_ff;
   logic [PW-1:0] lim_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          wr_pend_ff;
   logic          scr_ff;
   logic          inr_ff;

   // Effective window and clamped cursor
   logic [6:0]  w_c, wm1_c, ccol_c;
   logic [4:0]  h_c, hm1_c, crow_c;
   logic [11:0] rowbase_c, addr_c, pos_c;
   logic [12:0] lim_c;
   logic [7:0]  col_inc_c;
   logic        is_nl_c, is_pr_c, wrap_c, moved_c, scroll_c, idx_in_c, src_ok_c;
   logic [4:0]  row_n_c;
   logic [6:0]  col_n_c;
   logic [PW-1:0] ptr_m_w_c;

   // Memory port controls
   logic          we_c, re_c;
   logic [AW-1:0] wa_c, ra_c;
   logic [15:0]   wd_c;

   always_comb begin
      if (line_width_ff == 7'd0) begin
         w_c = 7'd1;
      end else if (32'(line_width_ff) > 32'(MAX_COLS)) begin
         w_c = 7'(MAX_COLS);
      end else begin
         w_c = line_width_ff;
      end
      if (line_count_ff == 5'd0) begin
         h_c = 5'd1;
      end else if (32'(line_count_ff) > 32'(MAX_ROWS)) begin
         h_c = 5'(MAX_ROWS);
      end else begin
         h_c = line_count_ff;
      end
   end

   assign wm1_c  = w_c - 7'd1;
   assign hm1_c  = h_c - 5'd1;
   assign crow_c = (cur_row_ff > hm1_c) ? hm1_c : cur_row_ff;
   assign ccol_c = (cur_col_ff > wm1_c) ? wm1_c : cur_col_ff;

   // Row base of the cursor; on a scroll this is the bottom row
   assign rowbase_c = {7'd0, crow_c} * {5'd0, w_c};
   assign addr_c    = rowbase_c + {5'd0, ccol_c};
   assign lim_c     = {1'b0, rowbase_c} + {6'd0, w_c};

   // Position reported in the response
   assign pos_c = ({7'd0, cur_row_ff} * {5'd0, w_c}) + {5'd0, cur_col_ff};

   // Character decode
   assign is_nl_c   = (char_ff == tcs_pkg::NEWLINE);
   assign is_pr_c   = (char_ff >= tcs_pkg::PRINT_LO) && (char_ff <= tcs_pkg::PRINT_HI);
   assign col_inc_c = {1'b0, ccol_c} + 8'd1;
   assign wrap_c    = is_pr_c && (col_inc_c >= {1'b0, w_c});
   assign moved_c   = is_nl_c || wrap_c;
   assign scroll_c  = (op_ff == tcs_pkg::OP_WRITE) && moved_c && (crow_c == hm1_c);

   always_comb begin
      row_n_c = crow_c;
      col_n_c = ccol_c;
      case (op_ff)
         tcs_pkg::OP_WRITE: begin
            if (moved_c) begin
               col_n_c = 7'd0;
               row_n_c = (crow_c == hm1_c) ? hm1_c : crow_c + 5'd1;
            end else if (is_pr_c) begin
               col_n_c = col_inc_c[6:0];
            end
         end
         tcs_pkg::OP_READ: begin
         end
         tcs_pkg::OP_CLEAR: begin
            row_n_c = 5'd0;
            col_n_c = 7'd0;
         end
         tcs_pkg::OP_MOVE: begin
            row_n_c = (trow_ff > hm1_c) ? hm1_c : trow_ff;
            col_n_c = (tcol_ff > wm1_c) ? wm1_c : tcol_ff;
         end
         default: begin
         end
      endcase
   end

   assign idx_in_c  = 32'(idx_ff) < 32'(CELL_COUNT);
   assign src_ok_c  = ptr_ff < lim_ff;
   assign ptr_m_w_c = ptr_ff - PW'(w_c);

   // Status to the controller
   assign status.op         = op_ff;
   assign status.scroll     = scroll_c;
   assign status.copy_done  = !src_ok_c && !wr_pend_ff;
   assign status.fill_last  = (ptr_ff == lim_ff - PW'(1));
   assign status.clear_last = (ptr_ff == PW'(CELL_COUNT - 1));

   // Memory port selection
   always_comb begin
      we_c = 1'b0;
      wa_c = '0;
      wd_c = tcs_pkg::BLANK_CELL;
      re_c = 1'b0;
      ra_c = '0;
      if (cmd.exec) begin
         if (op_ff == tcs_pkg::OP_WRITE && is_pr_c) begin
            we_c = 1'b1;
            wa_c = AW'(addr_c);
            wd_c = {tcs_pkg::TEXT_ATTR, char_ff};
         end
         if (op_ff == tcs_pkg::OP_READ && idx_in_c) begin
            re_c = 1'b1;
            ra_c = AW'(idx_ff);
         end
      end else if (cmd.copy) begin
         we_c = wr_pend_ff;
         wa_c = wr_addr_ff;
         wd_c = rd_q;
         re_c = src_ok_c;
         ra_c = AW'(ptr_ff);
      end else if (cmd.blank || cmd.clear) begin
         we_c = 1'b1;
         wa_c = AW'(ptr_ff);
      end
   end

   // Store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we_c) mem[wa_c] <= wd_c;
      if (re_c) rd_q <= mem[ra_c];
   end

   // Request capture and response registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= tcs_pkg::op_type'(req_op);
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
         trow_ff <= req_target_row;
         tcol_ff <= req_target_col;
      end
      if (cmd.exec) begin
         base_ff <= PW'(rowbase_c);
         lim_ff  <= PW'(lim_c);
         scr_ff  <= scroll_c;
         inr_ff  <= idx_in_c;
      end
      if (cmd.copy && src_ok_c) begin
         wr_addr_ff <= AW'(ptr_m_w_c);
      end
      if (cmd.finish) begin
         rsp_cursor_row      <= cur_row_ff;
         rsp_cursor_col      <= cur_col_ff;
         rsp_cursor_position <= 11'(pos_c);
         rsp_cell_data       <= (op_ff == tcs_pkg::OP_READ && inr_ff) ? rd_q : 16'd0;
         rsp_scrolled        <= scr_ff;
      end
   end

   // Control state: registers, cursor, sweep pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= tcs_pkg::LINE_WIDTH_RESET;
         line_count_ff <= tcs_pkg::LINE_COUNT_RESET;
         cur_row_ff    <= 5'd0;
         cur_col_ff    <= 7'd0;
         ptr_ff        <= '0;
         wr_pend_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (tcs_pkg::csr_type'(csr_index))
               tcs_pkg::CSR_LINE_WIDTH: line_width_ff <= csr_wdata;
               tcs_pkg::CSR_LINE_COUNT: line_count_ff <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end
         if (cmd.exec) begin
            cur_row_ff <= row_n_c;
            cur_col_ff <= col_n_c;
            ptr_ff     <= (op_ff == tcs_pkg::OP_CLEAR) ? '0 : PW'(w_c);
            wr_pend_ff <= 1'b0;
         end else if (cmd.blank_start) begin
            ptr_ff <= base_ff;
         end else if (cmd.copy) begin
            wr_pend_ff <= src_ok_c;
            if (src_ok_c) ptr_ff <= ptr_ff + PW'(1);
         end else if (cmd.blank || cmd.clear) begin
            ptr_ff <= ptr_ff + PW'(1);
         end
      end
   end

endmodule
